[hw/rtl/lcg_random_modulo_unit_assert.svh]
// assertion macros shared by the generator rtl
`ifndef LCG_RANDOM_MODULO_UNIT_ASSERT_SVH
`define LCG_RANDOM_MODULO_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCG_RM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCG_RM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcg_rm_pkg.sv]
// package: constants, types and states of the lcg random modulo unit
package lcg_rm_pkg;

    localparam int MOD_W = 32;
    localparam int RAW_W = 15;
    localparam int RAW_LSB = 16;
    localparam int CNT_W = $clog2(RAW_W);

    localparam logic [31:0] LCG_SEED = 32'd83838383;
    localparam logic [31:0] LCG_MULT = 32'd214013;
    localparam logic [31:0] LCG_INC = 32'd2531011;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hw/rtl/lcg_rm_req_if.sv]
// request channel: valid, ready and the modulus of one item
interface lcg_rm_req_if;
    logic valid;
    logic ready;
    logic [lcg_rm_pkg::MOD_W-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

[hw/rtl/lcg_rm_rsp_if.sv]
// result channel: valid, ready and the random value of one item
interface lcg_rm_rsp_if;
    logic valid;
    logic ready;
    logic [lcg_rm_pkg::RAW_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

[hw/rtl/lcg_random_modulo_unit.sv]
// top level: lcg state update, request and result channels, serial remainder
//
// channel  dir  payload
// req      in   modulus[31:0]
// rsp      out  random_value[14:0]
//
// from acceptance to its result an item passes a start cycle, the
// one-bit-per-cycle remainder loop over the 15 raw bits, and the output load
// req.ready is high only while no item is in work, so items never overlap in work
// the state advances on acceptance
// a result waits in the output register while the next item is accepted
// reset loads the seed 83838383 at once, no clearing pass
`include "lcg_random_modulo_unit_assert.svh"

module lcg_random_modulo_unit (
    input logic         clk,
    input logic         rst_n,
    lcg_rm_req_if.sink  req,
    lcg_rm_rsp_if.source rsp
);

    lcg_rm_pkg::state_t           state_reg;
    lcg_rm_pkg::state_t           state_next;
    logic [31:0]                  gen_state_reg;
    logic [31:0]                  gen_state_next;
    logic [lcg_rm_pkg::MOD_W-1:0] modulus_reg;
    logic                         start_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [lcg_rm_pkg::RAW_W-1:0] out_data_reg;
    logic                         accept;
    logic                         load_out;

    lcg_rm_pkg::div_ctrl_t        div_ctrl;
    lcg_rm_pkg::div_status_t      div_status;
    logic [lcg_rm_pkg::RAW_W-1:0] div_rem;

    assign accept = req.valid && req.ready;
    assign gen_state_next = gen_state_reg * lcg_rm_pkg::LCG_MULT + lcg_rm_pkg::LCG_INC;

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        req.ready  = 1'b0;
        case (state_reg)
            lcg_rm_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = lcg_rm_pkg::ST_RUN;
                end
            end
            lcg_rm_pkg::ST_RUN:
            begin
                if (div_status.done)
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        load_out   = 1'b1;
                        state_next = lcg_rm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lcg_rm_pkg::ST_HOLD;
                    end
                end
            end
            lcg_rm_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = lcg_rm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcg_rm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcg_rm_pkg::ST_IDLE;
            gen_state_reg <= lcg_rm_pkg::LCG_SEED;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                gen_state_reg <= gen_state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            modulus_reg <= req.modulus;
        end
        if (load_out)
        begin
            out_data_reg <= div_rem;
        end
    end

    assign div_ctrl.start = start_reg;

    lcg_rm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .raw       (gen_state_reg[lcg_rm_pkg::RAW_LSB +: lcg_rm_pkg::RAW_W]),
        .divisor   (modulus_reg),
        .status    (div_status),
        .remainder (div_rem)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.random_value = out_data_reg;

    `LCG_RM_ASSERT_NEXT(a_accept_run, clk, rst_n, accept,
        state_reg == lcg_rm_pkg::ST_RUN && div_ctrl.start, "accept did not start work")
    `LCG_RM_ASSERT_SAME(a_done_in_run, clk, rst_n, div_status.done,
        state_reg == lcg_rm_pkg::ST_RUN, "remainder done outside run")
    `LCG_RM_ASSERT_NEXT(a_load_valid, clk, rst_n, load_out, out_valid_reg,
        "loaded result not shown")

endmodule

[hw/rtl/lcg_rm_div.sv]
// bit-serial restoring remainder of the 15-bit raw value by the modulus
`include "lcg_random_modulo_unit_assert.svh"

module lcg_rm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcg_rm_pkg::div_ctrl_t           ctrl,
    input  logic [lcg_rm_pkg::RAW_W-1:0]    raw,
    input  logic [lcg_rm_pkg::MOD_W-1:0]    divisor,
    output lcg_rm_pkg::div_status_t         status,
    output logic [lcg_rm_pkg::RAW_W-1:0]    remainder
);

    logic [lcg_rm_pkg::RAW_W-1:0] dvd_reg;
    logic [lcg_rm_pkg::RAW_W-1:0] rem_reg;
    logic [lcg_rm_pkg::RAW_W-1:0] mod_reg;
    logic                         big_reg;
    logic                         zero_reg;
    logic [lcg_rm_pkg::CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [lcg_rm_pkg::RAW_W:0]   rem_sh;
    logic [lcg_rm_pkg::RAW_W:0]   rem_sub;
    logic                         take;

    assign rem_sh = {rem_reg, dvd_reg[lcg_rm_pkg::RAW_W-1]};
    assign take = !big_reg && (rem_sh >= {1'b0, mod_reg});
    assign rem_sub = take ? (rem_sh - {1'b0, mod_reg}) : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lcg_rm_pkg::CNT_W'(lcg_rm_pkg::RAW_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dvd_reg  <= raw;
            rem_reg  <= '0;
            mod_reg  <= divisor[lcg_rm_pkg::RAW_W-1:0];
            big_reg  <= |divisor[lcg_rm_pkg::MOD_W-1:lcg_rm_pkg::RAW_W];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[lcg_rm_pkg::RAW_W-2:0], 1'b0};
            rem_reg <= rem_sub[lcg_rm_pkg::RAW_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder = zero_reg ? '0 : rem_reg;

    `LCG_RM_ASSERT_SAME(a_start_idle, clk, rst_n, ctrl.start, !busy_reg, "start while busy")
    `LCG_RM_ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `LCG_RM_ASSERT_SAME(a_rem_bound, clk, rst_n, done_reg && !big_reg && !zero_reg,
        rem_reg < mod_reg, "remainder not below modulus")

endmodule
